// ----- design/oaht_pkg.sv -----
// Shared constants for the open addressing hash table.
// Holds operation, result and slot codes and the fixed field widths.
// No dependencies.
package oaht_pkg;

    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int VALUE_BITS  = 32;
    localparam int SLOT_BITS   = 2;

    // Request operations.
    localparam logic [KIND_BITS-1:0] KIND_GET = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SET = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DEL = 2'd2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd2;

    // Slot states held in the slot memory.
    localparam logic [SLOT_BITS-1:0] SLOT_FREE  = 2'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_TAKEN = 2'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_TOMB  = 2'd2;

endpackage

// ----- design/oaht_if.sv -----
// Request and response channel interfaces of the hash table.
// Depends on oaht_pkg for the field widths.

// Request channel: one beat per get, set or delete.
interface oaht_req_if
    import oaht_pkg::*;
#(
    parameter int KEY_BITS  = 32,
    parameter int HASH_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  key_hash;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, kind, key, key_hash, value, input ready);
    modport sink   (input valid, kind, key, key_hash, value, output ready);
endinterface

// Response channel: one beat per request.
interface oaht_rsp_if
    import oaht_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  found_value;

    modport source (output valid, status, found_value, input ready);
    modport sink   (input valid, status, found_value, output ready);
endinterface

// ----- design/oaht_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/open_addressing_hash_table.sv -----
// Open addressing hash table with perturbed probing. After reset the block
// clears the slot memory, one slot per cycle, and takes no request until
// the clearing pass is done. A request is then accepted, a 5-bit-per-cycle
// reduction unit forms the hash and every shifted perturb value modulo
// SLOTS, the first slot is read, and each probed slot is checked with the
// read of the next one started in the same cycle through the single read
// port of the slot memory; last, the output register is loaded once free.
// A request with an unused kind goes from acceptance straight to the output
// register. One request is in work at a time; a new one is accepted while
// the previous response still waits in the output register.
// Depends on oaht_pkg, oaht_if and oaht_ram.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS     = 512,
    parameter int KEY_BITS  = 32,
    parameter int HASH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    oaht_req_if.sink    req,
    oaht_rsp_if.source  rsp
);

    localparam int IDX_W       = $clog2(SLOTS);
    localparam int W2          = IDX_W + 3;
    localparam int NCHUNK      = (HASH_BITS + 4) / 5;
    localparam int HPAD        = NCHUNK * 5;
    localparam int CK_W        = $clog2(NCHUNK);
    localparam int PK_W        = $clog2(NCHUNK + 1);
    localparam int PROBE_LIMIT = 2 * SLOTS + 16;
    localparam int N_W         = $clog2(PROBE_LIMIT + 1);
    localparam int FC_W        = $clog2(SLOTS + 1);
    localparam int FILL_LIMIT  = (2 * SLOTS) / 3;
    localparam int WORD_W      = SLOT_BITS + KEY_BITS + VALUE_BITS;

    localparam logic [W2-1:0]    S1 = W2'(SLOTS);
    localparam logic [W2-1:0]    S2 = W2'(2 * SLOTS);
    localparam logic [W2-1:0]    S4 = W2'(4 * SLOTS);
    localparam logic [IDX_W:0]   SR = (IDX_W + 1)'(SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REM,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Control registers.
    state_t                  state_reg, state_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic [FC_W-1:0]         filled_reg, filled_next;

    // Request and probe working registers.
    logic [KIND_BITS-1:0]    kind_reg, kind_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic [HPAD-1:0]         hp_reg, hp_next;
    logic [IDX_W-1:0]        acc_reg, acc_next;
    logic [CK_W-1:0]         ck_reg, ck_next;
    logic [PK_W-1:0]         pk_reg, pk_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic                    tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0]        tomb_at_reg, tomb_at_next;
    logic [STATUS_BITS-1:0]  res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0]   res_found_reg, res_found_next;
    logic [STATUS_BITS-1:0]  out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0]   out_found_reg, out_found_next;
    logic [IDX_W-1:0]        rem_reg [NCHUNK];

    // Slot memory port signals.
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;

    logic [SLOT_BITS-1:0]    rd_status;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_value;

    logic                    rem_we;
    logic [IDX_W-1:0]        r_new;
    logic [IDX_W-1:0]        perturb_mod;
    logic [IDX_W-1:0]        i_step;

    assign rd_status = ram_rdata[WORD_W-1 -: SLOT_BITS];
    assign rd_key    = ram_rdata[VALUE_BITS +: KEY_BITS];
    assign rd_value  = ram_rdata[VALUE_BITS-1:0];

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_found_reg;

    // Slot memory: status, key and value of each slot in one word.
    oaht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Horner step of the hash reduction: fold the next 5 hash bits into the
    // running remainder, one restoring subtract per bit.
    always_comb
    begin
        logic [IDX_W:0] t;
        t = {1'b0, acc_reg};
        for (int b = 4; b >= 0; b--)
        begin
            t = {t[IDX_W-1:0], hp_reg[HPAD-5+b]};
            if (t >= SR)
            begin
                t = t - SR;
            end
        end
        r_new = t[IDX_W-1:0];
    end

    // Next probe slot: ((5*i + 1) mod SLOTS + perturb mod SLOTS) mod SLOTS.
    always_comb
    begin
        logic [W2-1:0] x;
        logic [W2-1:0] y;
        if (pk_reg < PK_W'(NCHUNK))
        begin
            perturb_mod = rem_reg[pk_reg[CK_W-1:0]];
        end
        else
        begin
            perturb_mod = '0;
        end
        x = (W2'(i_reg) << 2) + W2'(i_reg) + W2'(1);
        if (x >= S4)
        begin
            x = x - S4;
        end
        if (x >= S2)
        begin
            x = x - S2;
        end
        if (x >= S1)
        begin
            x = x - S1;
        end
        y = x + W2'(perturb_mod);
        if (y >= S1)
        begin
            y = y - S1;
        end
        i_step = y[IDX_W-1:0];
    end

    // Sequencer: clearing pass, request accept, hash reduction, probe walk, update and response.
    always_comb
    begin
        logic                    probe_end;
        logic                    hit;
        logic                    free_hit;
        logic                    tomb_any;
        logic [IDX_W-1:0]        tomb_pos;

        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        clr_next        = clr_reg;
        filled_next     = filled_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        hp_next         = hp_reg;
        acc_next        = acc_reg;
        ck_next         = ck_reg;
        pk_next         = pk_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        tomb_seen_next  = tomb_seen_reg;
        tomb_at_next    = tomb_at_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        ram_we          = 1'b0;
        ram_waddr       = i_reg;
        ram_wdata       = {SLOT_FREE, {KEY_BITS{1'b0}}, {VALUE_BITS{1'b0}}};
        ram_re          = 1'b0;
        ram_raddr       = i_reg;
        rem_we          = 1'b0;
        probe_end       = 1'b0;
        hit             = 1'b0;
        free_hit        = 1'b0;
        tomb_any        = tomb_seen_reg || (rd_status == SLOT_TOMB);
        tomb_pos        = tomb_seen_reg ? tomb_at_reg : i_reg;

        // A taken response beat frees the output register.
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    key_next       = req.key;
                    value_next     = req.value;
                    hp_next        = HPAD'(req.key_hash);
                    acc_next       = '0;
                    ck_next        = CK_W'(NCHUNK - 1);
                    pk_next        = '0;
                    n_next         = '0;
                    tomb_seen_next = 1'b0;
                    if (req.kind == KIND_GET || req.kind == KIND_SET ||
                        req.kind == KIND_DEL)
                    begin
                        state_next = ST_REM;
                    end
                    else
                    begin
                        res_status_next = STATUS_ABSENT;
                        res_found_next  = '0;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_REM:
            begin
                rem_we   = 1'b1;
                acc_next = r_new;
                hp_next  = hp_reg << 5;
                if (ck_reg == '0)
                begin
                    i_next     = r_new;
                    state_next = ST_READ;
                end
                else
                begin
                    ck_next = ck_reg - CK_W'(1);
                end
            end

            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                // Classify the slot just read.
                case (rd_status)
                    SLOT_FREE:
                    begin
                        probe_end = 1'b1;
                        free_hit  = 1'b1;
                    end
                    SLOT_TOMB:
                    begin
                        if (!tomb_seen_reg)
                        begin
                            tomb_seen_next = 1'b1;
                            tomb_at_next   = i_reg;
                        end
                    end
                    default:
                    begin
                        if (rd_key == key_reg)
                        begin
                            probe_end = 1'b1;
                            hit       = 1'b1;
                        end
                    end
                endcase
                if (n_reg == N_W'(PROBE_LIMIT - 1))
                begin
                    probe_end = 1'b1;
                end

                if (probe_end)
                begin
                    res_status_next = STATUS_ABSENT;
                    res_found_next  = '0;
                    state_next      = ST_DONE;
                    case (kind_reg)
                        KIND_GET:
                        begin
                            if (hit)
                            begin
                                res_status_next = STATUS_OK;
                                res_found_next  = rd_value;
                            end
                        end
                        KIND_SET:
                        begin
                            ram_wdata = {SLOT_TAKEN, key_reg, value_reg};
                            if (hit)
                            begin
                                ram_we          = 1'b1;
                                res_status_next = STATUS_OK;
                            end
                            else if (tomb_any)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = tomb_pos;
                                res_status_next = STATUS_OK;
                            end
                            else if (free_hit && filled_reg < FC_W'(FILL_LIMIT))
                            begin
                                ram_we          = 1'b1;
                                filled_next     = filled_reg + FC_W'(1);
                                res_status_next = STATUS_OK;
                            end
                            else
                            begin
                                res_status_next = STATUS_FULL;
                            end
                        end
                        KIND_DEL:
                        begin
                            if (hit)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = {SLOT_TOMB, rd_key, rd_value};
                                res_status_next = STATUS_OK;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_ABSENT;
                        end
                    endcase
                end
                else
                begin
                    // Move on and read the next slot right away.
                    ram_re    = 1'b1;
                    ram_raddr = i_step;
                    i_next    = i_step;
                    n_next    = n_reg + N_W'(1);
                    if (pk_reg < PK_W'(NCHUNK))
                    begin
                        pk_next = pk_reg + PK_W'(1);
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, response valid, clearing counter, fill count and output register, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            rsp_valid_reg  <= 1'b0;
            clr_reg        <= '0;
            filled_reg     <= '0;
            out_status_reg <= STATUS_OK;
            out_found_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            clr_reg        <= clr_next;
            filled_reg     <= filled_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
        end
    end

    // Working registers; each is loaded before it is read.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        hp_reg         <= hp_next;
        acc_reg        <= acc_next;
        ck_reg         <= ck_next;
        pk_reg         <= pk_next;
        n_reg          <= n_next;
        i_reg          <= i_next;
        tomb_seen_reg  <= tomb_seen_next;
        tomb_at_reg    <= tomb_at_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (rem_we)
        begin
            rem_reg[ck_reg] <= r_new;
        end
    end

    // No request is taken while the clearing pass runs.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request accepted during slot clearing");

    // The filled slot count stays within the load limit.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FC_W'(FILL_LIMIT))
        else $error("filled slot count above load limit");

    // The slot memory is written only by the clearing pass or a probe result.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_CHECK))
        else $error("slot write outside clearing or update");

    // An update ends the probe walk.
    a_write_ends_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && ram_we) |=> (state_reg == ST_DONE))
        else $error("probe continued after slot update");

endmodule

// ----- tb/oaht_answer_checker.sv -----
// Response checker for the open addressing hash table.
// Watches the request and response channels, keeps its own slot table and
// compares each response beat with the predicted one. Depends on oaht_pkg, oaht_if.
module oaht_answer_checker
    import oaht_pkg::*;
#(
    parameter int unsigned SLOTS     = 512,
    parameter int          KEY_BITS  = 32,
    parameter int          HASH_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    oaht_req_if  req,
    oaht_rsp_if  rsp,
    output int   mismatches,
    output int   awaited
);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  found_value;
    } answer_t;

    // Mirror of the slot memory and the two occupancy counters.
    logic [SLOT_BITS-1:0]  slot_mode  [SLOTS];
    logic [KEY_BITS-1:0]   slot_key   [SLOTS];
    logic [VALUE_BITS-1:0] slot_value [SLOTS];
    int unsigned           live_slots;
    int unsigned           filled_slots;
    int unsigned           rsp_beats;

    // Answers owed by the block, oldest first.
    answer_t answers_due [$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("oaht check: response beat %0d: %s", rsp_beats, what);
        mismatches++;
    endtask

    // Walks the probe sequence for one request, updates the mirror and
    // returns the answer the block must give.
    function automatic answer_t predict_answer(
        input logic [KIND_BITS-1:0]  kind,
        input logic [KEY_BITS-1:0]   key,
        input logic [HASH_BITS-1:0]  hash,
        input logic [VALUE_BITS-1:0] value
    );
        answer_t              ans;
        int unsigned          at;
        int unsigned          hit_at;
        int unsigned          free_at;
        int unsigned          tomb_at;
        int unsigned          claim_at;
        int unsigned          steps;
        logic [HASH_BITS-1:0] perturb;
        bit                   hit;
        bit                   free_seen;
        bit                   tomb_seen;
        bit                   claim;
        bit                   done;

        ans.status      = STATUS_ABSENT;
        ans.found_value = '0;
        if (kind != KIND_GET && kind != KIND_SET && kind != KIND_DEL)
            return ans;

        hit       = 1'b0;
        free_seen = 1'b0;
        tomb_seen = 1'b0;
        done      = 1'b0;
        hit_at    = 0;
        free_at   = 0;
        tomb_at   = 0;
        steps     = 0;
        at        = hash % SLOTS;
        perturb   = hash;

        // The probe ends at a free slot or a matching key; tombstones are
        // skipped, but the first one is remembered for reuse by a set.
        while (!done && steps < 2 * SLOTS + 16)
        begin
            if (slot_mode[at] == SLOT_FREE)
            begin
                free_seen = 1'b1;
                free_at   = at;
                done      = 1'b1;
            end
            else if (slot_mode[at] == SLOT_TOMB)
            begin
                if (!tomb_seen)
                begin
                    tomb_seen = 1'b1;
                    tomb_at   = at;
                end
            end
            else if (slot_key[at] == key)
            begin
                hit    = 1'b1;
                hit_at = at;
                done   = 1'b1;
            end
            if (!done)
            begin
                at      = ((5 * at + 1) % SLOTS + perturb % SLOTS) % SLOTS;
                perturb = perturb >> 5;
                steps++;
            end
        end

        case (kind)
            KIND_GET:
            begin
                if (hit)
                begin
                    ans.status      = STATUS_OK;
                    ans.found_value = slot_value[hit_at];
                end
            end
            KIND_SET:
            begin
                claim    = 1'b0;
                claim_at = 0;
                if (hit)
                begin
                    slot_value[hit_at] = value;
                    ans.status         = STATUS_OK;
                end
                else
                begin
                    // A new key takes the first tombstone, else the free slot
                    // if the fill limit of two thirds still allows it.
                    if (tomb_seen)
                    begin
                        claim    = 1'b1;
                        claim_at = tomb_at;
                    end
                    else if (free_seen && (filled_slots + 1) * 3 <= SLOTS * 2)
                    begin
                        claim    = 1'b1;
                        claim_at = free_at;
                        filled_slots++;
                    end
                    if (claim)
                    begin
                        slot_mode[claim_at]  = SLOT_TAKEN;
                        slot_key[claim_at]   = key;
                        slot_value[claim_at] = value;
                        live_slots++;
                        ans.status = STATUS_OK;
                    end
                    else
                    begin
                        ans.status = STATUS_FULL;
                    end
                end
            end
            default:
            begin
                if (hit)
                begin
                    slot_mode[hit_at] = SLOT_TOMB;
                    if (live_slots > 0)
                        live_slots--;
                    ans.status = STATUS_OK;
                end
            end
        endcase
        return ans;
    endfunction

    // Requests are predicted before responses are compared in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin : track
        int      s;
        answer_t want;

        if (!rst_n)
        begin
            for (s = 0; s < SLOTS; s++)
                slot_mode[s] = SLOT_FREE;
            live_slots   = 0;
            filled_slots = 0;
            rsp_beats    = 0;
            mismatches   = 0;
            answers_due.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                answers_due.push_back(predict_answer(req.kind, req.key,
                                                     req.key_hash, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch("beat with no request waiting");
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.found_value !== want.found_value)
                        report_mismatch($sformatf("found_value %h, expected %h",
                                                  rsp.found_value, want.found_value));
                end
                rsp_beats++;
            end
        end
        awaited = answers_due.size();
    end

endmodule

// ----- tb/tb_open_addressing_hash_table.sv -----
// Top of the hash table testbench: clock, reset, request stimulus,
// response stalls, watchdog and verdict. Depends on oaht_pkg, oaht_if,
// open_addressing_hash_table and oaht_answer_checker.
module tb_open_addressing_hash_table
    import oaht_pkg::*;
();

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int                   POOL_SIZE   = 256;
    localparam int                   QUIET_LIMIT = 4000;

    // Directed keys: the two extremes plus two more keys that share hash zero with the low key.
    localparam logic [31:0] KEY_LOW    = 32'h0000_0000;
    localparam logic [31:0] KEY_HIGH   = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_SECOND = 32'h1234_5678;
    localparam logic [31:0] KEY_THIRD  = 32'h8765_4321;
    localparam logic [31:0] HASH_LOW   = 32'h0000_0000;
    localparam logic [31:0] HASH_HIGH  = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited;
    int   burst_left;

    logic [31:0] pool_key  [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];

    oaht_req_if req_ch ();
    oaht_rsp_if rsp_ch ();

    open_addressing_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    oaht_answer_checker answer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Half of the hashes crowd the first sixteen slots to force long probes.
    function automatic logic [31:0] pick_hash();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return ($urandom & ~32'h1FF) | $urandom_range(0, 15);
    endfunction

    // Sends one request beat; the sender idles between bursts of random length.
    task automatic send_request(
        input logic [KIND_BITS-1:0] kind,
        input logic [31:0]          key,
        input logic [31:0]          hash,
        input logic [31:0]          value
    );
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.key      <= key;
        req_ch.key_hash <= hash;
        req_ch.value    <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Holds the request channel idle until every answer has come back.
    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (awaited != 0);
    endtask

    // Response stalls: quiet windows alternate with random stalls.
    initial
    begin : receiver
        int stall;
        int tick;

        rsp_ch.ready = 1'b0;
        stall = 0;
        tick  = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (tick % 1024 >= 256 && $urandom_range(0, 5) == 0)
                    stall = $urandom_range(1, 20);
            end
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_open_addressing_hash_table: errors");
        $finish;
    end

    initial
    begin : stimulus
        int          sent;
        int          pick;
        int          slot;
        logic [31:0] fresh_key;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = KIND_GET;
        req_ch.key      = '0;
        req_ch.key_hash = '0;
        req_ch.value    = '0;
        burst_left      = 0;
        for (slot = 0; slot < POOL_SIZE; slot++)
        begin
            pool_key[slot]  = $urandom;
            pool_hash[slot] = pick_hash();
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, overwrite, collisions on hash zero,
        // tombstones passed and reused, absent keys and the unused kind.
        send_request(KIND_GET, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_DEL, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_SET, KEY_LOW, HASH_LOW, 32'h0000_0000);
        send_request(KIND_SET, KEY_HIGH, HASH_HIGH, 32'hFFFF_FFFF);
        send_request(KIND_GET, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_GET, KEY_HIGH, HASH_HIGH, $urandom);
        send_request(KIND_SET, KEY_LOW, HASH_LOW, 32'hA5A5_5A5A);
        send_request(KIND_GET, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_SET, KEY_SECOND, HASH_LOW, 32'h5A5A_A5A5);
        send_request(KIND_GET, KEY_SECOND, HASH_LOW, $urandom);
        send_request(KIND_DEL, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_GET, KEY_LOW, HASH_LOW, $urandom);
        send_request(KIND_GET, KEY_SECOND, HASH_LOW, $urandom);
        send_request(KIND_SET, KEY_SECOND, HASH_LOW, 32'h0F0F_F0F0);
        send_request(KIND_SET, KEY_THIRD, HASH_LOW, 32'hF0F0_0F0F);
        send_request(KIND_GET, KEY_THIRD, HASH_LOW, $urandom);
        send_request(KIND_DEL, KEY_HIGH, HASH_HIGH, $urandom);
        send_request(KIND_DEL, KEY_HIGH, HASH_HIGH, $urandom);
        send_request(KIND_UNUSED, KEY_HIGH, HASH_HIGH, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED, KEY_LOW, HASH_LOW, 32'h0000_0000);
        send_request(KIND_SET, KEY_HIGH, HASH_HIGH, 32'h1357_9BDF);
        send_request(KIND_GET, KEY_HIGH, HASH_HIGH, $urandom);
        drain_answers();

        // Light load: a few dozen keys, many hits, deletes and reuses.
        sent = 0;
        while (sent < 900)
        begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, 31);
            if (pick < 40)
                send_request(KIND_SET, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 70)
                send_request(KIND_GET, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 90)
                send_request(KIND_DEL, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 95)
                send_request(($urandom_range(0, 1) == 0) ? KIND_GET : KIND_DEL,
                             $urandom, $urandom, $urandom);
            else
                send_request(KIND_UNUSED, $urandom, $urandom, $urandom);
            if (pick < 95)
                sent++;
        end
        drain_answers();

        // Heavy load: fresh keys fill the table up to the two-thirds limit,
        // after which sets of new keys are refused until tombstones open room again.
        sent = 0;
        while (sent < 930)
        begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SIZE - 1);
            if (pick < 45)
            begin
                fresh_key       = $urandom;
                pool_key[slot]  = fresh_key;
                pool_hash[slot] = pick_hash();
                send_request(KIND_SET, fresh_key, pool_hash[slot], $urandom);
            end
            else if (pick < 60)
                send_request(KIND_SET, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 80)
                send_request(KIND_GET, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 93)
                send_request(KIND_DEL, pool_key[slot], pool_hash[slot], $urandom);
            else if (pick < 97)
                send_request(($urandom_range(0, 1) == 0) ? KIND_GET : KIND_DEL,
                             $urandom, $urandom, $urandom);
            else
                send_request(KIND_UNUSED, $urandom, $urandom, $urandom);
            if (pick < 97)
                sent++;
        end
        drain_answers();

        // Give a stray extra beat time to show up before the verdict.
        repeat (24) @(negedge clk);
        if (mismatches == 0)
            $display("tb_open_addressing_hash_table: clean");
        else
            $display("tb_open_addressing_hash_table: errors");
        $finish;
    end

endmodule
